### rtl/crc_checked_packet_receiver_defines.svh
// Assertion macros used by the checker file of the packet receiver.
`ifndef CRC_CHECKED_PACKET_RECEIVER_DEFINES_SVH
`define CRC_CHECKED_PACKET_RECEIVER_DEFINES_SVH

// Property checked at every clock edge outside of reset.
`define CRCPR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define CRCPR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/crcpr_pkg.sv
package crcpr_pkg;

	// Request codes carried in req_type.
	typedef enum logic [1:0] {
		REQ_RX   = 2'd0,
		REQ_POP  = 2'd1,
		REQ_SEND = 2'd2,
		REQ_NACK = 2'd3
	} req_t;

	// Deframer phase. The fourth code is unused and acts as PH_HEADER.
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_CHECK  = 2'd2
	} phase_t;

	// Receive event codes.
	localparam logic [2:0] EV_NONE         = 3'd0;
	localparam logic [2:0] EV_STORED       = 3'd1;
	localparam logic [2:0] EV_CRC_BAD      = 3'd2;
	localparam logic [2:0] EV_FULL_DROP    = 3'd3;
	localparam logic [2:0] EV_RETX_SERVED  = 3'd4;
	localparam logic [2:0] EV_UNKNOWN_UTIL = 3'd5;
	localparam logic [2:0] EV_BAD_TYPE     = 3'd6;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_TYPE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UTILITY_TYPE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RETX_CODE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NACK_CODE    = 3'd5;

	// Configuration reset values.
	localparam logic [7:0] CRC_POLY_RST     = 8'h07;
	localparam logic [7:0] CRC_INIT_RST     = 8'h00;
	localparam logic [1:0] NORMAL_TYPE_RST  = 2'd1;
	localparam logic [1:0] UTILITY_TYPE_RST = 2'd2;
	localparam logic [7:0] RETX_CODE_RST    = 8'h01;
	localparam logic [7:0] NACK_CODE_RST    = 8'h02;

	// Packet format.
	localparam int         MAX_PAYLOAD_BYTES = 6;
	localparam int         PAYLOAD_W         = 8 * MAX_PAYLOAD_BYTES;
	localparam int         BC_W              = 3;
	localparam logic [7:0] RETX_HEADER       = 8'h06;
	localparam logic [7:0] UTIL_HDR_BASE     = 8'h04;
	localparam logic [7:0] FILL_BYTE         = 8'hFF;

	// One packet as held in the receive FIFO and the last-sent register.
	typedef struct packed {
		logic [7:0]           check;
		logic [PAYLOAD_W-1:0] payload;
		logic [7:0]           header;
	} pkt_t;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [7:0]           rx_byte;
		logic [7:0]           send_header;
		logic [PAYLOAD_W-1:0] send_payload;
		logic [7:0]           send_check;
	} in_item_t;

	typedef struct packed {
		logic                 tx_valid;
		logic [7:0]           tx_header;
		logic [PAYLOAD_W-1:0] tx_payload;
		logic [7:0]           tx_check;
		logic                 pop_valid;
		logic [7:0]           pop_header;
		logic [PAYLOAD_W-1:0] pop_payload;
		logic [7:0]           pop_check;
		logic [2:0]           rx_event;
		logic [3:0]           packets_waiting;
		logic                 fifo_full;
	} out_item_t;

	// CRC-8 over one byte, MSB first, no reflection.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

endpackage

### rtl/crc_checked_packet_receiver.sv
// A transaction accepted at the input is registered into stage 1, and its result is
// registered into the output register when stage 1 advances.
// Throughput: one transaction per cycle while in_stall is low; the per-byte CRC update
// and the FIFO access both fit between the stage 1 register and the output register.
// Reset: control state and configuration return to their defaults, then the utility
// packet CRCs are rebuilt with in_stall high (also after any configuration write). The
// FIFO memory itself is not cleared.
module crc_checked_packet_receiver import crcpr_pkg::*; #(
	parameter int PAYLOAD_BYTES = 6,
	parameter int BUF_DEPTH     = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	localparam int PTR_W = $clog2(BUF_DEPTH);
	localparam int CNT_W = $clog2(BUF_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUF_DEPTH - 1);
	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(BUF_DEPTH);
	localparam logic [BC_W-1:0]  LAST_BC  = BC_W'(PAYLOAD_BYTES);

	// Configuration registers.
	logic [7:0] crc_poly_q, crc_init_q, retx_code_q, nack_code_q;
	logic [1:0] normal_type_q, utility_type_q;

	// Utility packet CRC precompute.
	logic            pre_busy_q;
	logic [BC_W-1:0] pre_step_q;
	logic [7:0]      retx_crc_q, nack_crc_q;
	logic [7:0]      pre_retx_base, pre_nack_base, pre_retx_byte, pre_nack_byte;
	logic [7:0]      util_header;

	// Stage 1 and output register.
	logic      valid_s1, s1_go, in_fire;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_data_q;

	// Deframer and FIFO state.
	phase_t               phase_q, phase_d;
	logic [BC_W-1:0]      bc_q, bc_d, bc_inc;
	logic                 data_last;
	logic [7:0]           asm_header_q, asm_header_d;
	logic [PAYLOAD_W-1:0] asm_payload_q, asm_payload_d;
	logic [7:0]           run_crc_q, run_crc_d;
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q, rd_next;
	logic [CNT_W-1:0]     fill_q, fill_d;
	pkt_t                 last_sent_q;

	// FIFO memory with registered head read and write-to-head bypass.
	pkt_t fifo_mem [BUF_DEPTH];
	pkt_t head_q, head_byp_q, head;
	logic head_byp_sel_q;

	// Per-item decisions.
	logic      push, pop, emit, push_en, pop_en, retx_match;
	pkt_t      emit_pkt, push_pkt, retx_pkt, nack_pkt, send_pkt;
	logic [2:0] rx_ev;
	out_item_t res;

	function automatic logic [PAYLOAD_W-1:0] util_payload(input logic [7:0] code);
		logic [PAYLOAD_W-1:0] p;
		p = '0;
		p[7:0] = code;
		for (int i = 1; i < MAX_PAYLOAD_BYTES; i++) begin
			if (i < PAYLOAD_BYTES) begin
				p[8*i +: 8] = FILL_BYTE;
			end
		end
		return p;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q     <= CRC_POLY_RST;
			crc_init_q     <= CRC_INIT_RST;
			normal_type_q  <= NORMAL_TYPE_RST;
			utility_type_q <= UTILITY_TYPE_RST;
			retx_code_q    <= RETX_CODE_RST;
			nack_code_q    <= NACK_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CRC_POLY:     crc_poly_q     <= cfg_wdata;
				CFG_CRC_INIT:     crc_init_q     <= cfg_wdata;
				CFG_NORMAL_TYPE:  normal_type_q  <= cfg_wdata[1:0];
				CFG_UTILITY_TYPE: utility_type_q <= cfg_wdata[1:0];
				CFG_RETX_CODE:    retx_code_q    <= cfg_wdata;
				CFG_NACK_CODE:    nack_code_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign util_header = UTIL_HDR_BASE | {6'd0, utility_type_q};

	// Byte fed to the precompute chains: header, then code, then fill bytes.
	always_comb begin
		pre_retx_base = retx_crc_q;
		pre_nack_base = nack_crc_q;
		pre_retx_byte = FILL_BYTE;
		pre_nack_byte = FILL_BYTE;
		if (pre_step_q == '0) begin
			pre_retx_base = crc_init_q;
			pre_nack_base = crc_init_q;
			pre_retx_byte = util_header;
			pre_nack_byte = util_header;
		end else if (pre_step_q == BC_W'(1)) begin
			pre_retx_byte = retx_code_q;
			pre_nack_byte = nack_code_q;
		end
	end

	// Precompute sequencer, restarted by reset and by every configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_busy_q <= 1'b1;
			pre_step_q <= '0;
		end else if (cfg_we) begin
			pre_busy_q <= 1'b1;
			pre_step_q <= '0;
		end else if (pre_busy_q) begin
			pre_step_q <= pre_step_q + BC_W'(1);
			if (pre_step_q == LAST_BC) begin
				pre_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pre_busy_q) begin
			retx_crc_q <= crc8_byte(pre_retx_base, pre_retx_byte, crc_poly_q);
			nack_crc_q <= crc8_byte(pre_nack_base, pre_nack_byte, crc_poly_q);
		end
	end

	// Handshake: stage 1 advances whenever the output register is free or being emptied.
	assign s1_go    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = pre_busy_q || (valid_s1 && !s1_go);
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !s1_go);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_data;
		end
	end

	// Generated and host packets.
	always_comb begin
		retx_pkt.header  = util_header;
		retx_pkt.payload = util_payload(retx_code_q);
		retx_pkt.check   = retx_crc_q;
		nack_pkt.header  = util_header;
		nack_pkt.payload = util_payload(nack_code_q);
		nack_pkt.check   = nack_crc_q;
		send_pkt.header  = item_s1.send_header;
		send_pkt.payload = item_s1.send_payload;
		send_pkt.check   = item_s1.send_check;
		push_pkt.header  = asm_header_q;
		push_pkt.payload = asm_payload_q;
		push_pkt.check   = item_s1.rx_byte;
	end

	// Retransmit request match: fixed header, retx code, then fill bytes.
	always_comb begin
		retx_match = (asm_header_q == RETX_HEADER) && (asm_payload_q[7:0] == retx_code_q);
		for (int i = 1; i < MAX_PAYLOAD_BYTES; i++) begin
			if (i < PAYLOAD_BYTES && asm_payload_q[8*i +: 8] != FILL_BYTE) begin
				retx_match = 1'b0;
			end
		end
	end

	assign bc_inc    = bc_q + BC_W'(1);
	assign data_last = (bc_inc >= LAST_BC);

	// Deframer next phase.
	always_comb begin
		phase_d = phase_q;
		if (s1_go && item_s1.req_type == REQ_RX) begin
			unique case (phase_q)
				PH_DATA:  phase_d = data_last ? PH_CHECK : PH_DATA;
				PH_CHECK: phase_d = PH_HEADER;
				default:  phase_d = PH_DATA;
			endcase
		end
	end

	// Per-item work: assembly, CRC, check decision, FIFO and transmit selection.
	always_comb begin
		bc_d          = bc_q;
		asm_header_d  = asm_header_q;
		asm_payload_d = asm_payload_q;
		run_crc_d     = run_crc_q;
		push          = 1'b0;
		pop           = 1'b0;
		emit          = 1'b0;
		emit_pkt      = '0;
		rx_ev         = EV_NONE;
		case (item_s1.req_type)
			REQ_RX: begin
				unique case (phase_q)
					PH_DATA: begin
						for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
							if (i < PAYLOAD_BYTES && bc_q == BC_W'(i)) begin
								asm_payload_d[8*i +: 8] = item_s1.rx_byte;
							end
						end
						run_crc_d = crc8_byte(run_crc_q, item_s1.rx_byte, crc_poly_q);
						bc_d      = data_last ? '0 : bc_inc;
					end
					PH_CHECK: begin
						run_crc_d = crc_init_q;
						if (run_crc_q != item_s1.rx_byte) begin
							emit     = 1'b1;
							emit_pkt = retx_pkt;
							rx_ev    = EV_CRC_BAD;
						end else if (asm_header_q[1:0] == normal_type_q) begin
							if (fill_q == FILL_MAX) begin
								rx_ev = EV_FULL_DROP;
							end else begin
								push  = 1'b1;
								rx_ev = EV_STORED;
							end
						end else if (asm_header_q[1:0] == utility_type_q) begin
							if (retx_match) begin
								emit     = 1'b1;
								emit_pkt = last_sent_q;
								rx_ev    = EV_RETX_SERVED;
							end else begin
								rx_ev = EV_UNKNOWN_UTIL;
							end
						end else begin
							rx_ev = EV_BAD_TYPE;
						end
					end
					default: begin
						asm_header_d  = item_s1.rx_byte;
						asm_payload_d = '0;
						bc_d          = '0;
						run_crc_d     = crc8_byte(crc_init_q, item_s1.rx_byte, crc_poly_q);
					end
				endcase
			end
			REQ_POP: begin
				pop = (fill_q != '0);
			end
			REQ_SEND: begin
				emit     = 1'b1;
				emit_pkt = send_pkt;
			end
			REQ_NACK: begin
				emit     = 1'b1;
				emit_pkt = nack_pkt;
			end
			default: ;
		endcase
	end

	assign push_en = s1_go && push;
	assign pop_en  = s1_go && pop;
	assign rd_next = pop_en ? ptr_inc(rd_ptr_q) : rd_ptr_q;
	assign head    = head_byp_sel_q ? head_byp_q : head_q;

	// FIFO fill after this item.
	always_comb begin
		fill_d = fill_q;
		if (push_en) begin
			fill_d = fill_q + CNT_W'(1);
		end else if (pop_en) begin
			fill_d = fill_q - CNT_W'(1);
		end
	end

	// Result assembly.
	always_comb begin
		res                 = '0;
		res.tx_valid        = emit;
		res.tx_header       = emit_pkt.header;
		res.tx_payload      = emit_pkt.payload;
		res.tx_check        = emit_pkt.check;
		res.pop_valid       = pop;
		if (pop) begin
			res.pop_header  = head.header;
			res.pop_payload = head.payload;
			res.pop_check   = head.check;
		end
		res.rx_event        = rx_ev;
		res.packets_waiting = 4'(fill_d);
		res.fifo_full       = (fill_d == FILL_MAX);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			bc_q           <= '0;
			asm_header_q   <= '0;
			asm_payload_q  <= '0;
			run_crc_q      <= CRC_INIT_RST;
			wr_ptr_q       <= '0;
			rd_ptr_q       <= '0;
			fill_q         <= '0;
			last_sent_q    <= '0;
			head_byp_sel_q <= 1'b0;
		end else begin
			head_byp_sel_q <= push_en && (wr_ptr_q == rd_next);
			if (s1_go) begin
				phase_q       <= phase_d;
				bc_q          <= bc_d;
				asm_header_q  <= asm_header_d;
				asm_payload_q <= asm_payload_d;
				run_crc_q     <= run_crc_d;
				fill_q        <= fill_d;
				rd_ptr_q      <= rd_next;
				if (push) begin
					wr_ptr_q <= ptr_inc(wr_ptr_q);
				end
				if (emit) begin
					last_sent_q <= emit_pkt;
				end
			end
		end
	end

	// FIFO memory: one write port, one registered read of the next head entry.
	always_ff @(posedge clk) begin
		if (push_en) begin
			fifo_mem[wr_ptr_q] <= push_pkt;
		end
		head_q     <= fifo_mem[rd_next];
		head_byp_q <= push_pkt;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### rtl/crcpr_checker.sv
`include "crc_checked_packet_receiver_defines.svh"

module crcpr_checker import crcpr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	logic out_wait, tx_idle, tx_fields_zero, retx_event;

	assign out_wait       = out_valid && out_stall;
	assign tx_idle        = out_valid && !out_data.tx_valid;
	assign tx_fields_zero = out_data.tx_header == 8'd0 && out_data.tx_payload == '0
		&& out_data.tx_check == 8'd0;
	assign retx_event     = out_data.rx_event == EV_CRC_BAD
		|| out_data.rx_event == EV_RETX_SERVED;

	// A stalled result transaction stays put.
	`CRCPR_ASSERT(a_out_hold, out_wait |=> out_valid && $stable(out_data), "stalled result changed")

	// Transmit fields are zero when no packet goes out.
	`CRCPR_ASSERT(a_tx_idle_zero, tx_idle |-> tx_fields_zero, "tx fields not zero while idle")

	// A bad check or a served retransmit request always puts a packet on the bus.
	`CRCPR_ASSERT(a_retx_emits, out_valid && retx_event |-> out_data.tx_valid, "retransmit event without packet")

	// From the first clock edge under reset on, no result is shown.
	`CRCPR_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "result valid during reset")

endmodule

bind crc_checked_packet_receiver crcpr_checker u_crcpr_checker (.*);
